// ===== rtl/core/lrupr_pkg.sv =====
// Shared types and constants for the LRU page replacement block.
`timescale 1ns / 1ps
`default_nettype none

package lrupr_pkg;

   localparam int CSR_W       = 5;
   localparam int PAGE_PORT_W = 16;
   localparam int COUNT_W     = 32;
   localparam int STAMP_W     = 32;

   // Widest frame index and page key that the parameter ranges allow.
   localparam int IDX_MAX_W  = 8;
   localparam int PAGE_MAX_W = 32;

   localparam logic [CSR_W-1:0] NUM_FRAMES_RESET = 5'd4;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_SCAN
   } state_type;

   // Outcome of one pass over the frames.
   typedef struct packed {
      logic                  hit;
      logic [IDX_MAX_W-1:0]  hit_idx;
      logic                  free;
      logic [IDX_MAX_W-1:0]  free_idx;
      logic [IDX_MAX_W-1:0]  lru_idx;
      logic [PAGE_MAX_W-1:0] lru_page;
   } scan_result_type;

endpackage

`default_nettype wire

// ===== rtl/core/lrupr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module lrupr_ram #(
   parameter  int WIDTH = 32,
   parameter  int DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [AW-1:0]            wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [AW-1:0]            rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/lrupr_scan.sv =====
// Frame scan: one pass over the frame memories for the hit, first free frame and LRU frame.
`timescale 1ns / 1ps
`default_nettype none

module lrupr_scan import lrupr_pkg::*; #(
   parameter  int MAX_FRAMES = 16,
   parameter  int PAGE_BITS  = 16,
   localparam int IDX_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
   localparam int CNT_W      = $clog2(MAX_FRAMES + 1)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start_scan,
   input  wire logic [CNT_W-1:0]       frame_count,
   input  wire logic [PAGE_BITS-1:0]   key,
   input  wire logic [STAMP_W-1:0]     stamp,
   input  wire logic [MAX_FRAMES-1:0]  frame_valid,
   output logic                        rd_en,
   output logic      [IDX_W-1:0]       rd_addr,
   input  wire logic [PAGE_BITS-1:0]   rd_page,
   input  wire logic [STAMP_W-1:0]     rd_stamp,
   output logic                        scan_done,
   output scan_result_type             scan_result
);

   // Control state.
   logic             issuing_ff, issuing_in;
   logic [CNT_W-1:0] addr_ff, addr_in;
   logic             s1_vld_ff, s1_vld_in;
   logic             s1_last_ff, s1_last_in;
   logic             s2_vld_ff, s2_vld_in;
   logic             s2_last_ff, s2_last_in;
   logic             done_ff, done_in;
   logic             hit_found_ff, hit_found_in;
   logic             free_found_ff, free_found_in;
   logic             any_ff, any_in;

   // Payload.
   logic [IDX_W-1:0]     s1_idx_ff, s1_idx_in;
   logic [IDX_W-1:0]     s2_idx_ff, s2_idx_in;
   logic [STAMP_W-1:0]   s2_age_ff, s2_age_in;
   logic [PAGE_BITS-1:0] s2_page_ff, s2_page_in;
   logic [IDX_W-1:0]     hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0]     free_idx_ff, free_idx_in;
   logic [STAMP_W-1:0]   best_age_ff, best_age_in;
   logic [IDX_W-1:0]     best_idx_ff, best_idx_in;
   logic [PAGE_BITS-1:0] best_page_ff, best_page_in;

   logic at_last;

   assign at_last = (addr_ff == (frame_count - CNT_W'(1)));

   always_comb begin
      issuing_in    = issuing_ff;
      addr_in       = addr_ff;
      hit_found_in  = hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      any_in        = any_ff;
      best_age_in   = best_age_ff;
      best_idx_in   = best_idx_ff;
      best_page_in  = best_page_ff;

      // Address issue: one read of both memories per cycle.
      if (start_scan) begin
         issuing_in    = 1'b1;
         addr_in       = '0;
         hit_found_in  = 1'b0;
         free_found_in = 1'b0;
         any_in        = 1'b0;
      end else if (issuing_ff) begin
         addr_in = addr_ff + CNT_W'(1);
         if (at_last) begin
            issuing_in = 1'b0;
         end
      end

      s1_vld_in  = issuing_ff;
      s1_last_in = issuing_ff && at_last;
      s1_idx_in  = addr_ff[IDX_W-1:0];

      // Read data is back: tag match and free-frame search, lowest index wins.
      if (s1_vld_ff) begin
         if (!hit_found_ff && frame_valid[s1_idx_ff] && (rd_page == key)) begin
            hit_found_in = 1'b1;
            hit_idx_in   = s1_idx_ff;
         end
         if (!free_found_ff && !frame_valid[s1_idx_ff]) begin
            free_found_in = 1'b1;
            free_idx_in   = s1_idx_ff;
         end
      end

      s2_vld_in  = s1_vld_ff;
      s2_last_in = s1_vld_ff && s1_last_ff;
      s2_idx_in  = s1_idx_ff;
      s2_age_in  = stamp - rd_stamp;
      s2_page_in = rd_page;

      // Oldest frame so far; a strict compare keeps the lower index on a tie.
      if (s2_vld_ff && (!any_ff || (s2_age_ff > best_age_ff))) begin
         any_in       = 1'b1;
         best_age_in  = s2_age_ff;
         best_idx_in  = s2_idx_ff;
         best_page_in = s2_page_ff;
      end

      done_in = s2_vld_ff && s2_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issuing_ff    <= 1'b0;
         addr_ff       <= '0;
         s1_vld_ff     <= 1'b0;
         s1_last_ff    <= 1'b0;
         s2_vld_ff     <= 1'b0;
         s2_last_ff    <= 1'b0;
         done_ff       <= 1'b0;
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         any_ff        <= 1'b0;
      end else begin
         issuing_ff    <= issuing_in;
         addr_ff       <= addr_in;
         s1_vld_ff     <= s1_vld_in;
         s1_last_ff    <= s1_last_in;
         s2_vld_ff     <= s2_vld_in;
         s2_last_ff    <= s2_last_in;
         done_ff       <= done_in;
         hit_found_ff  <= hit_found_in;
         free_found_ff <= free_found_in;
         any_ff        <= any_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff    <= s1_idx_in;
      s2_idx_ff    <= s2_idx_in;
      s2_age_ff    <= s2_age_in;
      s2_page_ff   <= s2_page_in;
      hit_idx_ff   <= hit_idx_in;
      free_idx_ff  <= free_idx_in;
      best_age_ff  <= best_age_in;
      best_idx_ff  <= best_idx_in;
      best_page_ff <= best_page_in;
   end

   assign rd_en   = issuing_ff;
   assign rd_addr = addr_ff[IDX_W-1:0];

   assign scan_done            = done_ff;
   assign scan_result.hit      = hit_found_ff;
   assign scan_result.hit_idx  = IDX_MAX_W'(hit_idx_ff);
   assign scan_result.free     = free_found_ff;
   assign scan_result.free_idx = IDX_MAX_W'(free_idx_ff);
   assign scan_result.lru_idx  = IDX_MAX_W'(best_idx_ff);
   assign scan_result.lru_page = PAGE_MAX_W'(best_page_ff);

endmodule

`default_nettype wire

// ===== rtl/core/lru_page_replacement.sv =====
// Top level of the fully associative LRU page replacement block.
`timescale 1ns / 1ps
`default_nettype none

// One page reference is taken per start beat while busy is low. The block
// then reads the page and last-use memories once per frame in use, matching
// the tag, noting the first free frame and tracking the oldest frame in the
// same pass, and in the commit cycle writes the last-use memory and, on a
// miss, the page memory. Busy stays high from accept until that commit, so
// no new reference is taken before the last one commits; each memory has one
// read port, so frames are read in turn. The result beat appears on the
// rsp_ ports for a single cycle marked by rsp_valid and cannot be stalled,
// and busy is already low in that cycle, so the next start may be taken
// alongside it. Only the low PAGE_BITS bits of a page number are used;
// a frame count of zero acts as one, a count above MAX_FRAMES as MAX_FRAMES.
module lru_page_replacement import lrupr_pkg::*; #(
   parameter int MAX_FRAMES = 16,
   parameter int PAGE_BITS  = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [PAGE_PORT_W-1:0] req_page_number,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_W-1:0]       csr_write_data,
   output logic                        rsp_valid,
   output logic                        rsp_hit,
   output logic                        rsp_evict_valid,
   output logic      [PAGE_PORT_W-1:0] rsp_evicted_page,
   output logic      [COUNT_W-1:0]     rsp_hit_total,
   output logic      [COUNT_W-1:0]     rsp_miss_total
);

   localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int CNT_W = $clog2(MAX_FRAMES + 1);

   state_type             state_ff, state_in;
   logic [CSR_W-1:0]      num_frames_ff, num_frames_in;
   logic [CNT_W-1:0]      n_ff, n_in;
   logic [PAGE_BITS-1:0]  key_ff, key_in;
   logic [STAMP_W-1:0]    stamp_ff, stamp_in;
   logic [COUNT_W-1:0]    hit_count_ff, hit_count_in;
   logic [COUNT_W-1:0]    miss_count_ff, miss_count_in;
   logic [MAX_FRAMES-1:0] valid_ff, valid_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_hit_ff, rsp_hit_in;
   logic                   rsp_evict_valid_ff, rsp_evict_valid_in;
   logic [PAGE_PORT_W-1:0] rsp_evicted_page_ff, rsp_evicted_page_in;
   logic [COUNT_W-1:0]     rsp_hit_total_ff, rsp_hit_total_in;
   logic [COUNT_W-1:0]     rsp_miss_total_ff, rsp_miss_total_in;

   logic                 accept;
   logic                 commit;
   logic [CNT_W-1:0]     n_active;
   logic [IDX_W-1:0]     slot;
   logic                 miss;
   logic                 evict;

   logic                 scan_rd_en;
   logic [IDX_W-1:0]     scan_rd_addr;
   logic [PAGE_BITS-1:0] rd_page;
   logic [STAMP_W-1:0]   rd_stamp;
   logic                 scan_done;
   scan_result_type      scan_result;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign commit = (state_ff == ST_SCAN) && scan_done;

   // Clamp the programmed frame count into 1 .. MAX_FRAMES.
   always_comb begin
      if (num_frames_ff == '0) begin
         n_active = CNT_W'(1);
      end else if (32'(num_frames_ff) > MAX_FRAMES) begin
         n_active = CNT_W'(MAX_FRAMES);
      end else begin
         n_active = CNT_W'(num_frames_ff);
      end
   end

   // Hit frame first, then the lowest free frame, else the LRU victim.
   always_comb begin
      miss  = !scan_result.hit;
      evict = miss && !scan_result.free;
      if (scan_result.hit) begin
         slot = scan_result.hit_idx[IDX_W-1:0];
      end else if (scan_result.free) begin
         slot = scan_result.free_idx[IDX_W-1:0];
      end else begin
         slot = scan_result.lru_idx[IDX_W-1:0];
      end
   end

   always_comb begin
      state_in            = state_ff;
      num_frames_in       = num_frames_ff;
      n_in                = n_ff;
      key_in              = key_ff;
      stamp_in            = stamp_ff;
      hit_count_in        = hit_count_ff;
      miss_count_in       = miss_count_ff;
      valid_in            = valid_ff;
      rsp_valid_in        = 1'b0;
      rsp_hit_in          = rsp_hit_ff;
      rsp_evict_valid_in  = rsp_evict_valid_ff;
      rsp_evicted_page_in = rsp_evicted_page_ff;
      rsp_hit_total_in    = rsp_hit_total_ff;
      rsp_miss_total_in   = rsp_miss_total_ff;

      if (csr_write_enable) begin
         num_frames_in = csr_write_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               n_in     = n_active;
               key_in   = PAGE_BITS'(32'(req_page_number));
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (commit) begin
               if (miss) begin
                  valid_in[slot] = 1'b1;
                  if (miss_count_ff != '1) begin
                     miss_count_in = miss_count_ff + COUNT_W'(1);
                  end
               end else if (hit_count_ff != '1) begin
                  hit_count_in = hit_count_ff + COUNT_W'(1);
               end
               stamp_in            = stamp_ff + STAMP_W'(1);
               rsp_valid_in        = 1'b1;
               rsp_hit_in          = !miss;
               rsp_evict_valid_in  = evict;
               rsp_evicted_page_in = evict ? scan_result.lru_page[PAGE_PORT_W-1:0] : '0;
               rsp_hit_total_in    = hit_count_in;
               rsp_miss_total_in   = miss_count_in;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         num_frames_ff <= NUM_FRAMES_RESET;
         stamp_ff      <= '0;
         hit_count_ff  <= '0;
         miss_count_ff <= '0;
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         num_frames_ff <= num_frames_in;
         stamp_ff      <= stamp_in;
         hit_count_ff  <= hit_count_in;
         miss_count_ff <= miss_count_in;
         valid_ff      <= valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff                <= n_in;
      key_ff              <= key_in;
      rsp_hit_ff          <= rsp_hit_in;
      rsp_evict_valid_ff  <= rsp_evict_valid_in;
      rsp_evicted_page_ff <= rsp_evicted_page_in;
      rsp_hit_total_ff    <= rsp_hit_total_in;
      rsp_miss_total_ff   <= rsp_miss_total_in;
   end

   // Writes happen only in the commit cycle and the next scan starts later,
   // so a read never overlaps a write to the same frame.
   lrupr_ram #(
      .WIDTH (PAGE_BITS),
      .DEPTH (MAX_FRAMES)
   ) u_page_ram (
      .clock   (clock),
      .wr_en   (commit && miss),
      .wr_addr (slot),
      .wr_data (key_ff),
      .rd_en   (scan_rd_en),
      .rd_addr (scan_rd_addr),
      .rd_data (rd_page)
   );

   lrupr_ram #(
      .WIDTH (STAMP_W),
      .DEPTH (MAX_FRAMES)
   ) u_stamp_ram (
      .clock   (clock),
      .wr_en   (commit),
      .wr_addr (slot),
      .wr_data (stamp_ff),
      .rd_en   (scan_rd_en),
      .rd_addr (scan_rd_addr),
      .rd_data (rd_stamp)
   );

   lrupr_scan #(
      .MAX_FRAMES (MAX_FRAMES),
      .PAGE_BITS  (PAGE_BITS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .start_scan  (accept),
      .frame_count (n_ff),
      .key         (key_ff),
      .stamp       (stamp_ff),
      .frame_valid (valid_ff),
      .rd_en       (scan_rd_en),
      .rd_addr     (scan_rd_addr),
      .rd_page     (rd_page),
      .rd_stamp    (rd_stamp),
      .scan_done   (scan_done),
      .scan_result (scan_result)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_evict_valid  = rsp_evict_valid_ff;
   assign rsp_evicted_page = rsp_evicted_page_ff;
   assign rsp_hit_total    = rsp_hit_total_ff;
   assign rsp_miss_total   = rsp_miss_total_ff;

endmodule

`default_nettype wire
